[src/seconds_to_calendar_date_assert.svh]
// Assertion macros shared by the checker of seconds_to_calendar_date.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// General clocked property, disabled while reset is held.
`define S2CD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that applies only on a cycle that carries a result.
`define S2CD_ASSERT_ON_DONE(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) done |-> (cond)) else $error(msg);

`endif

[src/s2cd_pkg.sv]
// Shared types and constants for the seconds-to-calendar-date pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package s2cd_pkg;

    // Bias of 6428268 days (44 eras) keeps the shifted seconds non-negative.
    localparam logic [40:0] SEC_BIAS   = 41'd555402355200;
    localparam logic [23:0] MARCH_BIAS = 24'd719468;

    // Stage counts of the pipeline parts.
    localparam int unsigned DAY_LAT    = 4;
    localparam int unsigned CLOCK_LAT  = 4;
    localparam int unsigned CIVIL_LAT  = 10;
    localparam int unsigned PIPE_LAT   = 1 + DAY_LAT + CIVIL_LAT;
    localparam int unsigned CLOCK_DLY  = CIVIL_LAT - CLOCK_LAT;

    // Exact reciprocals: floor(x / d) == (x * M) >> K for x below 2**(K - ceil(log2 d)).
    localparam int unsigned K_675_A = 28;
    localparam logic [18:0] M_675_A = 19'(((64'd1 << K_675_A) + 64'd674) / 64'd675);
    localparam int unsigned K_675_B = 36;
    localparam logic [26:0] M_675_B = 27'(((64'd1 << K_675_B) + 64'd674) / 64'd675);
    localparam int unsigned K_3600  = 29;
    localparam logic [17:0] M_3600  = 18'(((64'd1 << K_3600) + 64'd3599) / 64'd3600);
    localparam int unsigned K_60    = 18;
    localparam logic [12:0] M_60    = 13'(((64'd1 << K_60) + 64'd59) / 64'd60);
    localparam int unsigned K_7     = 27;
    localparam logic [24:0] M_7     = 25'(((64'd1 << K_7) + 64'd6) / 64'd7);
    localparam int unsigned K_ERA   = 42;
    localparam logic [24:0] M_ERA   = 25'(((64'd1 << K_ERA) + 64'd146096) / 64'd146097);
    localparam int unsigned K_1460  = 29;
    localparam logic [18:0] M_1460  = 19'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
    localparam int unsigned K_36524 = 34;
    localparam logic [18:0] M_36524 = 19'(((64'd1 << K_36524) + 64'd36523) / 64'd36524);
    localparam int unsigned K_365   = 27;
    localparam logic [18:0] M_365   = 19'(((64'd1 << K_365) + 64'd364) / 64'd365);
    localparam int unsigned K_100   = 16;
    localparam logic [9:0]  M_100   = 10'(((64'd1 << K_100) + 64'd99) / 64'd100);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
        logic [8:0]  doy;
    } date_t;

    // First day of each month in a March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start_day;
        unique case (mp)
            4'd0:    start_day = 9'd0;
            4'd1:    start_day = 9'd31;
            4'd2:    start_day = 9'd61;
            4'd3:    start_day = 9'd92;
            4'd4:    start_day = 9'd122;
            4'd5:    start_day = 9'd153;
            4'd6:    start_day = 9'd184;
            4'd7:    start_day = 9'd214;
            4'd8:    start_day = 9'd245;
            4'd9:    start_day = 9'd275;
            4'd10:   start_day = 9'd306;
            4'd11:   start_day = 9'd337;
            default: start_day = 9'd0;
        endcase
        return start_day;
    endfunction

endpackage

`default_nettype wire

[src/s2cd_day_split.sv]
// Splits biased seconds into a day number and a second of the day.
// Depends on s2cd_pkg; four pipeline stages, divides by 128 and then by 675.
`default_nettype none

module s2cd_day_split (
    input  logic        clk,
    input  logic [40:0] u,
    output logic [23:0] days,
    output logic [16:0] tod
);

    logic [17:0] a;
    logic [36:0] qa_prod;
    logic [7:0]  qa_next;
    logic [17:0] ra_full;
    logic [25:0] nx_next;
    logic [52:0] qb_prod;
    logic [15:0] qb_next;
    logic [25:0] rb_full;

    logic [7:0]  qa1_reg;
    logic [17:0] a1_reg;
    logic [15:0] vlo1_reg;
    logic [6:0]  slo1_reg;
    logic [25:0] nx2_reg;
    logic [7:0]  qa2_reg;
    logic [6:0]  slo2_reg;
    logic [15:0] qb3_reg;
    logic [25:0] nx3_reg;
    logic [7:0]  qa3_reg;
    logic [6:0]  slo3_reg;
    logic [23:0] days_reg;
    logic [16:0] tod_reg;

    // Long division by 675 in two digits of the seconds shifted down by 7.
    assign a       = u[40:23];
    assign qa_prod = a * s2cd_pkg::M_675_A;
    assign qa_next = qa_prod[s2cd_pkg::K_675_A +: 8];

    assign ra_full = a1_reg - 18'(qa1_reg) * 18'd675;
    assign nx_next = {ra_full[9:0], vlo1_reg};

    assign qb_prod = nx2_reg * s2cd_pkg::M_675_B;
    assign qb_next = qb_prod[s2cd_pkg::K_675_B +: 16];

    assign rb_full = nx3_reg - 26'(qb3_reg) * 26'd675;

    always_ff @(posedge clk)
    begin
        qa1_reg  <= qa_next;
        a1_reg   <= a;
        vlo1_reg <= u[22:7];
        slo1_reg <= u[6:0];

        nx2_reg  <= nx_next;
        qa2_reg  <= qa1_reg;
        slo2_reg <= slo1_reg;

        qb3_reg  <= qb_next;
        nx3_reg  <= nx2_reg;
        qa3_reg  <= qa2_reg;
        slo3_reg <= slo2_reg;

        days_reg <= {qa3_reg, qb3_reg};
        tod_reg  <= {rb_full[9:0], slo3_reg};
    end

    assign days = days_reg;
    assign tod  = tod_reg;

endmodule

`default_nettype wire

[src/s2cd_clock.sv]
// Breaks a second of the day into hour, minute and second.
// Depends on s2cd_pkg; four pipeline stages.
`default_nettype none

module s2cd_clock (
    input  logic           clk,
    input  logic [16:0]    tod,
    output s2cd_pkg::tod_t tm
);

    logic [34:0] hr_prod;
    logic [4:0]  hr_next;
    logic [11:0] rem_next;
    logic [24:0] mn_prod;
    logic [5:0]  mn_next;
    logic [11:0] sec_full;

    logic [16:0]    tod1_reg;
    logic [4:0]     hr1_reg;
    logic [11:0]    rem2_reg;
    logic [4:0]     hr2_reg;
    logic [11:0]    rem3_reg;
    logic [4:0]     hr3_reg;
    logic [5:0]     mn3_reg;
    s2cd_pkg::tod_t tm_reg;
    s2cd_pkg::tod_t tm_next;

    assign hr_prod  = tod * s2cd_pkg::M_3600;
    assign hr_next  = hr_prod[s2cd_pkg::K_3600 +: 5];
    assign rem_next = 12'(tod1_reg - 17'(hr1_reg) * 17'd3600);
    assign mn_prod  = rem2_reg * s2cd_pkg::M_60;
    assign mn_next  = mn_prod[s2cd_pkg::K_60 +: 6];
    assign sec_full = rem3_reg - 12'(mn3_reg) * 12'd60;

    always_comb
    begin
        tm_next.hour   = hr3_reg;
        tm_next.minute = mn3_reg;
        tm_next.second = sec_full[5:0];
    end

    always_ff @(posedge clk)
    begin
        tod1_reg <= tod;
        hr1_reg  <= hr_next;
        rem2_reg <= rem_next;
        hr2_reg  <= hr1_reg;
        rem3_reg <= rem2_reg;
        hr3_reg  <= hr2_reg;
        mn3_reg  <= mn_next;
        tm_reg   <= tm_next;
    end

    assign tm = tm_reg;

endmodule

`default_nettype wire

[src/s2cd_civil.sv]
// Turns a biased day number into weekday, year, month, day of month and day of year.
// Depends on s2cd_pkg; ten pipeline stages through era, year of era and month.
`default_nettype none

module s2cd_civil (
    input  logic            clk,
    input  logic [23:0]     days,
    output s2cd_pkg::date_t dt
);

    // Combinational values feeding each stage
    logic [23:0] zz_next;
    logic [23:0] wkx_next;
    logic [48:0] era_prod;
    logic [6:0]  era_next;
    logic [48:0] q7_prod;
    logic [20:0] q7_next;
    logic [23:0] doe_full;
    logic [23:0] wday_full;
    logic [36:0] q1460_prod;
    logic [6:0]  q1460_next;
    logic [36:0] q36524_prod;
    logic [2:0]  q36524_next;
    logic        last_next;
    logic [15:0] ybase_next;
    logic [17:0] t_next;
    logic [36:0] yoe_prod;
    logic [8:0]  yoe_next;
    logic [18:0] q100_prod;
    logic [1:0]  q100_next;
    logic [17:0] base_next;
    logic [17:0] doy_full;
    logic [8:0]  rem100_full;
    logic        leap_next;
    logic [3:0]  mp_next;
    logic        late;
    logic [8:0]  dom_full;
    s2cd_pkg::date_t dt_next;

    // Stage registers, numbered by stage
    logic [23:0] zz1_reg;
    logic [23:0] zz2_reg;
    logic [23:0] wkx2_reg;
    logic [6:0]  era2_reg;
    logic [20:0] q72_reg;
    logic [17:0] doe3_reg;
    logic [2:0]  wday3_reg;
    logic [6:0]  era3_reg;
    logic [6:0]  q1460_4_reg;
    logic [2:0]  q36524_4_reg;
    logic        last4_reg;
    logic [17:0] doe4_reg;
    logic [2:0]  wday4_reg;
    logic [15:0] ybase4_reg;
    logic [17:0] t5_reg;
    logic [17:0] doe5_reg;
    logic [2:0]  wday5_reg;
    logic [15:0] ybase5_reg;
    logic [8:0]  yoe6_reg;
    logic [17:0] doe6_reg;
    logic [2:0]  wday6_reg;
    logic [15:0] ybase6_reg;
    logic [1:0]  q100_7_reg;
    logic [17:0] base7_reg;
    logic [8:0]  yoe7_reg;
    logic [17:0] doe7_reg;
    logic [2:0]  wday7_reg;
    logic [15:0] ybase7_reg;
    logic [8:0]  doy8_reg;
    logic        leap8_reg;
    logic [8:0]  yoe8_reg;
    logic [2:0]  wday8_reg;
    logic [15:0] ybase8_reg;
    logic [3:0]  mp9_reg;
    logic [8:0]  doy9_reg;
    logic        leap9_reg;
    logic [8:0]  yoe9_reg;
    logic [2:0]  wday9_reg;
    logic [15:0] ybase9_reg;
    s2cd_pkg::date_t dt_reg;

    // Day count from 0000-03-01, still offset by 44 eras
    assign zz_next  = days + s2cd_pkg::MARCH_BIAS;

    // Era and weekday; the bias is a whole number of weeks, so add 3 for a Sunday base
    assign wkx_next = zz1_reg + 24'd3;
    assign era_prod = zz1_reg * s2cd_pkg::M_ERA;
    assign era_next = era_prod[s2cd_pkg::K_ERA +: 7];
    assign q7_prod  = wkx_next * s2cd_pkg::M_7;
    assign q7_next  = q7_prod[s2cd_pkg::K_7 +: 21];

    assign doe_full  = zz2_reg - 24'(era2_reg) * 24'd146097;
    assign wday_full = wkx2_reg - 24'(q72_reg) * 24'd7;

    assign q1460_prod  = doe3_reg * s2cd_pkg::M_1460;
    assign q1460_next  = q1460_prod[s2cd_pkg::K_1460 +: 7];
    assign q36524_prod = doe3_reg * s2cd_pkg::M_36524;
    assign q36524_next = q36524_prod[s2cd_pkg::K_36524 +: 3];
    assign last_next   = (doe3_reg == 18'd146096);
    // Year of the era start less 1900, with the 44-era bias removed
    assign ybase_next  = 16'(era3_reg) * 16'd400 - 16'd19500;

    assign t_next = doe4_reg - 18'(q1460_4_reg) + 18'(q36524_4_reg) - 18'(last4_reg);

    assign yoe_prod = t5_reg * s2cd_pkg::M_365;
    assign yoe_next = yoe_prod[s2cd_pkg::K_365 +: 9];

    assign q100_prod = yoe6_reg * s2cd_pkg::M_100;
    assign q100_next = q100_prod[s2cd_pkg::K_100 +: 2];
    assign base_next = 18'(yoe6_reg) * 18'd365 + 18'(yoe6_reg[8:2]);

    assign doy_full    = doe7_reg - base7_reg + 18'(q100_7_reg);
    assign rem100_full = yoe7_reg - 9'(q100_7_reg) * 9'd100;
    // Within an era the year is a multiple of 400 only at the era start
    assign leap_next   = (yoe7_reg[1:0] == 2'b00)
                         && ((rem100_full[6:0] != 7'd0) || (yoe7_reg == 9'd0));

    // Month of the March-based year: last month start not beyond the day
    always_comb
    begin
        mp_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy8_reg >= s2cd_pkg::month_start(4'(i)))
                mp_next = 4'(i);
        end
    end

    // January and February belong to the following calendar year
    assign late     = (mp9_reg >= 4'd10);
    assign dom_full = doy9_reg - s2cd_pkg::month_start(mp9_reg) + 9'd1;

    always_comb
    begin
        dt_next.weekday = wday9_reg;
        dt_next.year    = ybase9_reg + 16'(yoe9_reg) + 16'(late);
        dt_next.month   = late ? (mp9_reg - 4'd10) : (mp9_reg + 4'd2);
        dt_next.dom     = dom_full[4:0];
        dt_next.doy     = late ? (doy9_reg - 9'd306) : (doy9_reg + 9'd59 + 9'(leap9_reg));
    end

    always_ff @(posedge clk)
    begin
        zz1_reg      <= zz_next;

        zz2_reg      <= zz1_reg;
        wkx2_reg     <= wkx_next;
        era2_reg     <= era_next;
        q72_reg      <= q7_next;

        doe3_reg     <= doe_full[17:0];
        wday3_reg    <= wday_full[2:0];
        era3_reg     <= era2_reg;

        q1460_4_reg  <= q1460_next;
        q36524_4_reg <= q36524_next;
        last4_reg    <= last_next;
        doe4_reg     <= doe3_reg;
        wday4_reg    <= wday3_reg;
        ybase4_reg   <= ybase_next;

        t5_reg       <= t_next;
        doe5_reg     <= doe4_reg;
        wday5_reg    <= wday4_reg;
        ybase5_reg   <= ybase4_reg;

        yoe6_reg     <= yoe_next;
        doe6_reg     <= doe5_reg;
        wday6_reg    <= wday5_reg;
        ybase6_reg   <= ybase5_reg;

        q100_7_reg   <= q100_next;
        base7_reg    <= base_next;
        yoe7_reg     <= yoe6_reg;
        doe7_reg     <= doe6_reg;
        wday7_reg    <= wday6_reg;
        ybase7_reg   <= ybase6_reg;

        doy8_reg     <= doy_full[8:0];
        leap8_reg    <= leap_next;
        yoe8_reg     <= yoe7_reg;
        wday8_reg    <= wday7_reg;
        ybase8_reg   <= ybase7_reg;

        mp9_reg      <= mp_next;
        doy9_reg     <= doy8_reg;
        leap9_reg    <= leap8_reg;
        yoe9_reg     <= yoe8_reg;
        wday9_reg    <= wday8_reg;
        ybase9_reg   <= ybase8_reg;

        dt_reg       <= dt_next;
    end

    assign dt = dt_reg;

endmodule

`default_nettype wire

[src/seconds_to_calendar_date.sv]
// Top level: converts signed epoch seconds to civil date and time of day.
// Depends on s2cd_pkg, s2cd_day_split, s2cd_clock and s2cd_civil.
//
// One request is taken on every cycle that start is high; busy never rises.
// Each request yields one result, shown for one cycle with done high.
// The pipeline is made of an input register, four stages
// that split seconds into day and second of day, and ten stages of the
// calendar arithmetic, each divide by a constant being a reciprocal multiply
// followed by a stage of remainder.
// The receiver cannot stall, so results must be taken as they appear.
`default_nettype none

module seconds_to_calendar_date (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [39:0] unix_seconds,
    output logic               done,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic [2:0]         weekday,
    output logic signed [15:0] year_since_1900,
    output logic [3:0]         month,
    output logic [4:0]         day_of_month,
    output logic [8:0]         day_of_year
);

    logic                             accept;
    logic [40:0]                      u_next;
    logic [40:0]                      u_reg;
    logic [s2cd_pkg::PIPE_LAT-1:0]    vld_next;
    logic [s2cd_pkg::PIPE_LAT-1:0]    vld_reg;
    logic [23:0]                      days;
    logic [16:0]                      tod;
    s2cd_pkg::tod_t                   tm;
    s2cd_pkg::tod_t                   tm_dly_reg [s2cd_pkg::CLOCK_DLY];
    s2cd_pkg::date_t                  dt;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Bias to a non-negative value so every later division is unsigned floor
    assign u_next   = 41'(unix_seconds) + s2cd_pkg::SEC_BIAS;
    assign vld_next = {vld_reg[s2cd_pkg::PIPE_LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            u_reg <= u_next;
    end

    s2cd_day_split u_day_split (
        .clk  (clk),
        .u    (u_reg),
        .days (days),
        .tod  (tod)
    );

    s2cd_clock u_clock (
        .clk (clk),
        .tod (tod),
        .tm  (tm)
    );

    s2cd_civil u_civil (
        .clk  (clk),
        .days (days),
        .dt   (dt)
    );

    // Hold the time of day back until the date catches up
    always_ff @(posedge clk)
    begin
        tm_dly_reg[0] <= tm;
        for (int i = 1; i < s2cd_pkg::CLOCK_DLY; i++)
        begin
            tm_dly_reg[i] <= tm_dly_reg[i-1];
        end
    end

    assign done            = vld_reg[s2cd_pkg::PIPE_LAT-1];
    assign hour            = tm_dly_reg[s2cd_pkg::CLOCK_DLY-1].hour;
    assign minute          = tm_dly_reg[s2cd_pkg::CLOCK_DLY-1].minute;
    assign second          = tm_dly_reg[s2cd_pkg::CLOCK_DLY-1].second;
    assign weekday         = dt.weekday;
    assign year_since_1900 = dt.year;
    assign month           = dt.month;
    assign day_of_month    = dt.dom;
    assign day_of_year     = dt.doy;

endmodule

`default_nettype wire

[src/s2cd_checker.sv]
// Port-level checks for seconds_to_calendar_date, bound to the top level.
// Depends on s2cd_pkg and seconds_to_calendar_date_assert.svh.
`default_nettype none

`include "seconds_to_calendar_date_assert.svh"

module s2cd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [4:0] hour,
    input logic [5:0] minute,
    input logic [5:0] second,
    input logic [2:0] weekday,
    input logic [3:0] month,
    input logic [4:0] day_of_month,
    input logic [8:0] day_of_year
);

    `S2CD_ASSERT(a_never_busy, !busy, "busy raised although every request is taken")
    `S2CD_ASSERT_ON_DONE(a_fixed_latency, $past(start, s2cd_pkg::PIPE_LAT), "result without a request at the pipeline latency")
    `S2CD_ASSERT_ON_DONE(a_time_range, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6, "time of day or weekday out of range")
    `S2CD_ASSERT_ON_DONE(a_date_range, month <= 4'd11 && day_of_month != 5'd0 && day_of_year <= 9'd365, "date field out of range")
    `S2CD_ASSERT_ON_DONE(a_january_yday, month != 4'd0 || day_of_year + 9'd1 == {4'd0, day_of_month}, "day of year disagrees with a January date")

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (.*);

`default_nettype wire
